>>> design/mme_pkg.sv
// Shared types and constants for the matrix multiply engine.
// No dependencies; imported by the interface users, mme_mac and matrix_multiply_engine.
package mme_pkg;

    localparam int CFG_W  = 7;    // width of a size register
    localparam int IDX_W  = 6;    // width of a row or column index
    localparam int ELEM_W = 16;   // Q1.15 element
    localparam int PROD_W = 32;   // Q2.30 product
    localparam int SUM_W  = 38;   // Q8.30 sum
    localparam int DIM_W  = 11;   // holds any effective size up to 1024

    typedef logic [DIM_W-1:0] t_dim;

    // request codes; code 3 is ignored
    typedef logic [1:0] t_req_code;
    localparam t_req_code REQ_WR_A = 2'd0;
    localparam t_req_code REQ_WR_B = 2'd1;
    localparam t_req_code REQ_RD_C = 2'd2;

    // configuration register indexes; index 3 is ignored
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ROWS_M  = 2'd0;
    localparam t_cfg_idx CFG_INNER_N = 2'd1;
    localparam t_cfg_idx CFG_COLS_K  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef struct packed {
        t_req_code                 req_type;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic signed [ELEM_W-1:0]  elem_value;
    } t_req;

    typedef struct packed {
        logic signed [SUM_W-1:0] product_value;
        logic                    bad_index;
    } t_rsp;

    typedef struct packed {
        t_cfg_idx          reg_index;
        logic [CFG_W-1:0]  wr_data;
    } t_cfg;

    // control from the sequencer to the MAC unit
    typedef struct packed {
        logic clear;   // zero the accumulator
        logic vld;     // operands valid this cycle
        logic last;    // final term of the dot product
    } t_mac_ctl;

    // effective size: register value saturated to the build maximum
    function automatic t_dim clamp_dim(input logic [CFG_W-1:0] v, input t_dim maxv);
        t_dim ve;
        ve = DIM_W'(v);
        return (ve > maxv) ? maxv : ve;
    endfunction

endpackage

>>> design/mme_chan_if.sv
// Valid/ready channel carrying one payload of type T per transfer.
// Depends on nothing; payload types come from mme_pkg at instantiation.
interface mme_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/mme_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/mme_mac.sv
// Pipelined multiply-accumulate: registered Q2.30 product of Q1.15 operands, then Q8.30 sum.
// Depends on mme_pkg (t_mac_ctl, widths).
module mme_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mme_pkg::t_mac_ctl               i_ctl,
    input  logic signed [mme_pkg::ELEM_W-1:0] i_a,
    input  logic signed [mme_pkg::ELEM_W-1:0] i_b,
    output logic signed [mme_pkg::SUM_W-1:0]  o_sum,
    output logic                            o_done
);
    import mme_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_p_vld;
    logic                     r_p_last;
    logic signed [SUM_W-1:0]  r_acc;
    logic                     r_done;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_p_vld) begin
            r_acc <= r_acc + SUM_W'(r_prod);   // wraps mod 2^38
        end
        if (!i_rst_n) begin
            r_p_vld  <= 1'b0;
            r_p_last <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_p_vld  <= i_ctl.vld;
            r_p_last <= i_ctl.vld && i_ctl.last;
            r_done   <= r_p_vld && r_p_last;
        end
    end

    assign o_sum  = r_acc;
    assign o_done = r_done;
endmodule

>>> design/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: request sequencer, size registers,
// A and B element stores (mme_ram) and the MAC unit (mme_mac). Uses mme_pkg, mme_chan_if.
// Usage
//   i_req  : request channel (t_req). Write A, write B or read one element of C.
//   i_cfg  : register writes (t_cfg): rows_m, inner_n, cols_k; always ready;
//            must be written by the user only while the engine is idle; not enforced.
//   o_rsp  : one result (t_rsp) per read of C; writes and code 3 give none.
// Timing
//   A write lands in its store on the transfer and the engine stays ready for requests.
//   A read of C issues one A/B element pair per cycle through a single
//   multiplier, one pair for each term of the effective inner_n; then the
//   RAM read, product, accumulate and completion-flag stages follow and the
//   output register is loaded (64 MACs at full size).
//   Out-of-range reads and reads with inner_n zero skip issue and go straight to the final state.
//   One read is in flight at a time; the input is held off until it is done.
// Reset: size registers return to 64 and the sequencer goes idle. The stores
//   are not cleared: an element must be written before it is read.
// Back-pressure: the result sits in an output register; a new request is taken
//   while it waits. A read completing while the previous result is untaken
//   holds in its final state until o_rsp moves.
module matrix_multiply_engine #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_INNER = 64,
    parameter int MAX_COLS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mme_chan_if.sink    i_req,
    mme_chan_if.sink    i_cfg,
    mme_chan_if.source  o_rsp
);
    import mme_pkg::*;

    localparam int DEPTH_A = MAX_ROWS * MAX_INNER;
    localparam int DEPTH_B = MAX_INNER * MAX_COLS;
    localparam int AW_A    = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
    localparam int AW_B    = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
    localparam int LW      = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

    typedef enum logic [1:0] {
        S_IDLE,   // ready for a request
        S_RUN,    // issuing element pairs
        S_WAIT,   // draining the MAC pipeline
        S_FIN     // loading the output register
    } t_state;

    // registers
    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_rows_m, n_rows_m;
    logic [CFG_W-1:0]  r_inner_n, n_inner_n;
    logic [CFG_W-1:0]  r_cols_k, n_cols_k;
    logic [IDX_W-1:0]  r_row, n_row;
    logic [IDX_W-1:0]  r_col, n_col;
    logic [LW-1:0]     r_l, n_l;
    logic              r_bad, n_bad;
    logic              r_rd_vld, n_rd_vld;
    logic              r_rd_last, n_rd_last;
    logic              r_rsp_vld, n_rsp_vld;
    t_rsp              r_rsp, n_rsp;

    // combinational
    t_dim              em, en, ek;
    t_req              req;
    t_cfg              cfg;
    logic              req_xfer, cfg_xfer;
    t_dim              row_ext, col_ext;
    logic              a_we, b_we;
    logic              rd_start, rd_bad;
    logic              issue, issue_last;
    logic [AW_A-1:0]   a_waddr, a_raddr;
    logic [AW_B-1:0]   b_waddr, b_raddr;
    logic [ELEM_W-1:0] a_rdata, b_rdata;
    t_mac_ctl          mac_ctl;
    logic signed [SUM_W-1:0] mac_sum;
    logic              mac_done;

    // effective sizes, saturated to the build limits
    assign em = clamp_dim(r_rows_m, DIM_W'(MAX_ROWS));
    assign en = clamp_dim(r_inner_n, DIM_W'(MAX_INNER));
    assign ek = clamp_dim(r_cols_k, DIM_W'(MAX_COLS));

    assign req      = i_req.data;
    assign cfg      = i_cfg.data;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_xfer = i_req.valid && i_req.ready;
    assign cfg_xfer = i_cfg.valid && i_cfg.ready;

    assign row_ext = DIM_W'(req.row_index);
    assign col_ext = DIM_W'(req.col_index);

    // stores are written straight from the request; out-of-range writes dropped
    assign a_we = req_xfer && (req.req_type == REQ_WR_A) && (row_ext < em) && (col_ext < en);
    assign b_we = req_xfer && (req.req_type == REQ_WR_B) && (row_ext < en) && (col_ext < ek);
    assign a_waddr = AW_A'(req.row_index) * AW_A'(MAX_INNER) + AW_A'(req.col_index);
    assign b_waddr = AW_B'(req.row_index) * AW_B'(MAX_COLS) + AW_B'(req.col_index);

    assign rd_start = req_xfer && (req.req_type == REQ_RD_C);
    assign rd_bad   = (row_ext >= em) || (col_ext >= ek);

    // reads start the cycle after the transfer, so a write never overlaps
    // a read of the same element
    assign issue      = (r_state == S_RUN);
    assign issue_last = (DIM_W'(r_l) == en - DIM_W'(1));
    assign a_raddr    = AW_A'(r_row) * AW_A'(MAX_INNER) + AW_A'(r_l);
    assign b_raddr    = AW_B'(r_l) * AW_B'(MAX_COLS) + AW_B'(r_col);

    mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH_A), .AW(AW_A)) u_a_store (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (req.elem_value),
        .i_re    (issue),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH_B), .AW(AW_B)) u_b_store (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (req.elem_value),
        .i_re    (issue),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // accumulator cleared on the read transfer: bad or empty reads then
    // return zero from it unchanged
    assign mac_ctl.clear = rd_start;
    assign mac_ctl.vld   = r_rd_vld;
    assign mac_ctl.last  = r_rd_last;

    mme_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (a_rdata),
        .i_b     (b_rdata),
        .o_sum   (mac_sum),
        .o_done  (mac_done)
    );

    always_comb begin
        n_state   = r_state;
        n_rows_m  = r_rows_m;
        n_inner_n = r_inner_n;
        n_cols_k  = r_cols_k;
        n_row     = r_row;
        n_col     = r_col;
        n_l       = r_l;
        n_bad     = r_bad;
        n_rd_vld  = issue;
        n_rd_last = issue && issue_last;
        n_rsp_vld = r_rsp_vld && !o_rsp.ready;
        n_rsp     = r_rsp;

        if (cfg_xfer) begin
            case (cfg.reg_index)
                CFG_ROWS_M:  n_rows_m  = cfg.wr_data;
                CFG_INNER_N: n_inner_n = cfg.wr_data;
                CFG_COLS_K:  n_cols_k  = cfg.wr_data;
                default:     ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (rd_start) begin
                    n_row = req.row_index;
                    n_col = req.col_index;
                    n_l   = '0;
                    n_bad = rd_bad;
                    n_state = (rd_bad || (en == '0)) ? S_FIN : S_RUN;
                end
            end
            S_RUN: begin
                n_l = r_l + LW'(1);
                if (issue_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (mac_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_rsp_vld || o_rsp.ready) begin
                    n_rsp_vld = 1'b1;
                    n_rsp.product_value = mac_sum;
                    n_rsp.bad_index     = r_bad;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
        r_l   <= n_l;
        r_bad <= n_bad;
        r_rsp <= n_rsp;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rows_m  <= CFG_RESET;
            r_inner_n <= CFG_RESET;
            r_cols_k  <= CFG_RESET;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rows_m  <= n_rows_m;
            r_inner_n <= n_inner_n;
            r_cols_k  <= n_cols_k;
            r_rd_vld  <= n_rd_vld;
            r_rd_last <= n_rd_last;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    assign o_rsp.valid = r_rsp_vld;
    assign o_rsp.data  = r_rsp;

    // store writes never coincide with element reads
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (!a_we && !b_we))
        else $error("store write during read issue");

    // the MAC only completes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_state == S_WAIT))
        else $error("MAC completion outside wait state");

    // a result leaving the final state is presented next cycle
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && (!r_rsp_vld || o_rsp.ready)) |=> (r_rsp_vld && (r_state == S_IDLE)))
        else $error("result not loaded");

    // a bad-index result always carries zero
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_vld && r_rsp.bad_index) |-> (r_rsp.product_value == '0))
        else $error("bad-index result not zero");

endmodule
